// ===== hdl/dcd_pkg.sv =====
// Package for the day-count to calendar-date converter.
// Holds shared constants, controller/datapath interface structs and calendar tables.
// No dependencies.
`default_nettype none

package dcd_pkg;

    localparam int DAY_COUNT_BITS_DEF = 16;
    localparam int IN_W               = 16;
    localparam int OUT_DATA_W         = 24;
    // wide enough for the last year reachable with a 20-bit day count
    localparam int YEAR_W             = 13;
    localparam int YEAR_OUT_W         = 12;

    localparam logic [YEAR_W-1:0] EPOCH_YEAR    = 13'd1980;
    localparam logic [1:0]        EPOCH_MOD4    = 2'd0;
    localparam logic [6:0]        EPOCH_MOD100  = 7'd80;
    localparam logic [8:0]        EPOCH_MOD400  = 9'd380;
    localparam logic [2:0]        EPOCH_WEEKDAY = 3'd2;
    localparam logic [3:0]        MONTH_LAST    = 4'd11;

    typedef struct packed {
        logic load;
        logic year_step;
        logic month_step;
        logic finish;
    } dcd_cmd_t;

    typedef struct packed {
        logic zero;
        logic year_more;
        logic month_more;
    } dcd_sts_t;

    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        begin
            case (idx)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // weekday plus a step of at most 3, kept in 0..6
    function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] inc);
        logic [3:0] sum;
        begin
            sum = {1'b0, wd} + {1'b0, inc};
            if (sum >= 4'd7) begin
                sum = sum - 4'd7;
            end
            return sum[2:0];
        end
    endfunction

    // mod 7 of a value below 42
    function automatic logic [2:0] mod7_small(input logic [5:0] v);
        logic [5:0] r;
        begin
            if (v >= 6'd35) begin
                r = v - 6'd35;
            end else if (v >= 6'd28) begin
                r = v - 6'd28;
            end else if (v >= 6'd21) begin
                r = v - 6'd21;
            end else if (v >= 6'd14) begin
                r = v - 6'd14;
            end else if (v >= 6'd7) begin
                r = v - 6'd7;
            end else begin
                r = v;
            end
            return r[2:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/dcd_datapath.sv =====
// Datapath of the day-count converter: remainder, year, month, weekday registers
// and the result register. Driven by dcd_ctrl commands. Uses dcd_pkg.
`default_nettype none

module dcd_datapath #(
    parameter int DAY_COUNT_BITS = dcd_pkg::DAY_COUNT_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire  [dcd_pkg::IN_W-1:0]            in_data,
    input  wire  dcd_pkg::dcd_cmd_t             cmd,
    output dcd_pkg::dcd_sts_t                   sts,
    output logic [dcd_pkg::OUT_DATA_W-1:0]      out_data,
    output logic                                out_invalid
);

    logic [31:0]                     in_ext;
    logic [DAY_COUNT_BITS-1:0]       count;
    logic [DAY_COUNT_BITS-1:0]       rem_reg;
    logic [DAY_COUNT_BITS-1:0]       rem_next;
    logic [dcd_pkg::YEAR_W-1:0]      year_reg;
    logic [dcd_pkg::YEAR_W-1:0]      year_next;
    logic [1:0]                      m4_reg;
    logic [1:0]                      m4_next;
    logic [6:0]                      m100_reg;
    logic [6:0]                      m100_next;
    logic [8:0]                      m400_reg;
    logic [8:0]                      m400_next;
    logic [3:0]                      month_reg;
    logic [3:0]                      month_next;
    logic [2:0]                      wd_reg;
    logic [2:0]                      wd_next;
    logic                            inv_reg;
    logic                            inv_next;
    logic [dcd_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [dcd_pkg::OUT_DATA_W-1:0]  out_data_next;
    logic                            out_inv_reg;
    logic                            out_inv_next;
    logic                            leap;
    logic [8:0]                      year_len;
    logic [4:0]                      mlen;
    logic [5:0]                      wd_sum;

    assign in_ext = {{(32 - dcd_pkg::IN_W){1'b0}}, in_data};
    assign count  = in_ext[DAY_COUNT_BITS-1:0];

    assign leap     = (m400_reg == 9'd0) || ((m4_reg == 2'd0) && (m100_reg != 7'd0));
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mlen     = dcd_pkg::month_len(month_reg, leap);
    assign wd_sum   = {3'b000, wd_reg} + {1'b0, rem_reg[4:0]} - 6'd1;

    assign sts.zero       = (count == '0);
    assign sts.year_more  = rem_reg > DAY_COUNT_BITS'(year_len);
    assign sts.month_more = (month_reg < dcd_pkg::MONTH_LAST) &&
                            (rem_reg > DAY_COUNT_BITS'(mlen));

    always_comb begin
        rem_next      = rem_reg;
        year_next     = year_reg;
        m4_next       = m4_reg;
        m100_next     = m100_reg;
        m400_next     = m400_reg;
        month_next    = month_reg;
        wd_next       = wd_reg;
        inv_next      = inv_reg;
        out_data_next = out_data_reg;
        out_inv_next  = out_inv_reg;
        if (cmd.load) begin
            rem_next   = count;
            year_next  = dcd_pkg::EPOCH_YEAR;
            m4_next    = dcd_pkg::EPOCH_MOD4;
            m100_next  = dcd_pkg::EPOCH_MOD100;
            m400_next  = dcd_pkg::EPOCH_MOD400;
            month_next = '0;
            wd_next    = dcd_pkg::EPOCH_WEEKDAY;
            inv_next   = sts.zero;
        end else if (cmd.year_step) begin
            rem_next  = rem_reg - DAY_COUNT_BITS'(year_len);
            year_next = year_reg + {{(dcd_pkg::YEAR_W-1){1'b0}}, 1'b1};
            m4_next   = m4_reg + 2'd1;
            m100_next = (m100_reg == 7'd99) ? 7'd0 : m100_reg + 7'd1;
            m400_next = (m400_reg == 9'd399) ? 9'd0 : m400_reg + 9'd1;
            wd_next   = dcd_pkg::wd_add(wd_reg, leap ? 3'd2 : 3'd1);
        end else if (cmd.month_step) begin
            rem_next   = rem_reg - DAY_COUNT_BITS'(mlen);
            month_next = month_reg + 4'd1;
            wd_next    = dcd_pkg::wd_add(wd_reg, 3'(mlen - 5'd28));
        end
        if (cmd.finish) begin
            if (inv_reg) begin
                out_data_next = '0;
                out_inv_next  = 1'b1;
            end else begin
                out_data_next = {dcd_pkg::mod7_small(wd_sum), rem_reg[4:0],
                                 month_reg + 4'd1, year_reg[dcd_pkg::YEAR_OUT_W-1:0]};
                out_inv_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg      <= rem_next;
        year_reg     <= year_next;
        m4_reg       <= m4_next;
        m100_reg     <= m100_next;
        m400_reg     <= m400_next;
        month_reg    <= month_next;
        wd_reg       <= wd_next;
        inv_reg      <= inv_next;
        out_data_reg <= out_data_next;
        out_inv_reg  <= out_inv_next;
    end

    assign out_data    = out_data_reg;
    assign out_invalid = out_inv_reg;

endmodule

`default_nettype wire

// ===== hdl/dcd_ctrl.sv =====
// Controller of the day-count converter: sequences load, year walk, month walk
// and result hand-off, and owns the result valid flag. Uses dcd_pkg.
`default_nettype none

module dcd_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire                     m_ready,
    input  wire  dcd_pkg::dcd_sts_t sts,
    output dcd_pkg::dcd_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_YEAR  = 2'd1;
    localparam logic [1:0] ST_MONTH = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = sts.zero ? ST_FIN : ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (sts.year_more) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (sts.month_more) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!out_valid_reg || m_ready))
        else $error("result overwritten before transaction");

    a_load_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg != ST_IDLE))
        else $error("load did not start a conversion");

    a_year_done_in_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MONTH) |-> !sts.year_more)
        else $error("remainder exceeds year length during month walk");

    a_finish_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid)
        else $error("finish did not present a result");
`endif

endmodule

`default_nettype wire

// ===== hdl/day_count_to_calendar_date.sv =====
// Top level of the day-count to calendar-date converter.
// Instantiates dcd_ctrl and dcd_datapath; uses dcd_pkg.
//
// Converts a day count (1 = Tuesday 1 January 1980) into Gregorian year, month,
// day of month and weekday (Sunday = 0). Only the low DAY_COUNT_BITS bits of the
// count are used; a count of zero returns all-zero fields with tuser set. One
// conversion is in flight at a time: a transaction is a load step, one step per
// whole year walked plus one to close the year walk, one per whole month walked
// (at most 11) plus one to close the month walk, and a step that writes the
// result register, which waits while the result register still holds an
// untaken date; a zero count goes from the load straight to the result write.
// The serial year walk dominates the conversion time. The result register holds
// a finished date until taken, and a new count is accepted meanwhile.
`default_nettype none

module day_count_to_calendar_date #(
    parameter int DAY_COUNT_BITS = dcd_pkg::DAY_COUNT_BITS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [dcd_pkg::IN_W-1:0]            s_axis_tdata,  // [15:0] days_since_epoch
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [23:21] day_of_week
    output logic [dcd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tuser   // [0] invalid
);

    dcd_pkg::dcd_cmd_t cmd;
    dcd_pkg::dcd_sts_t sts;

    dcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dcd_datapath #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .in_data     (s_axis_tdata),
        .cmd         (cmd),
        .sts         (sts),
        .out_data    (m_axis_tdata),
        .out_invalid (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== tb/day_count_to_calendar_date_tb.sv =====
// Testbench for day_count_to_calendar_date: directed table plus random day counts,
// with random idling on both stream sides, results checked against typed table dates or a local date predictor.
// Depends on dcd_pkg and the day_count_to_calendar_date RTL.
module day_count_to_calendar_date_tb;

    localparam int RANDOM_COUNTS = 600;
    localparam int DRAIN_CYCLES  = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_CAP    = 50;
    localparam int FEBRUARY      = 1;
    localparam int DECEMBER      = 11;

    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef enum logic [2:0] {
        SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY, SATURDAY
    } weekday_t;

    // same bit order as {m_axis_tuser, m_axis_tdata}
    typedef struct packed {
        logic        invalid;
        logic [2:0]  wday;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [11:0] year;
    } calendar_date_t;

    typedef struct packed {
        logic [15:0]    count;
        logic           typed;
        calendar_date_t date;
    } directed_row_t;

    typedef struct {
        logic [15:0]    count;
        calendar_date_t date;
    } pending_date_t;

    localparam int DIRECTED_ROWS = 24;

    // typed rows carry the date; the rest go through the predictor
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{16'd0,     1'b1, '{1'b1, 3'd0,      5'd0,  4'd0,  12'd0}},
        '{16'd1,     1'b1, '{1'b0, TUESDAY,   5'd1,  4'd1,  12'd1980}},
        '{16'd60,    1'b1, '{1'b0, FRIDAY,    5'd29, 4'd2,  12'd1980}},
        '{16'd366,   1'b1, '{1'b0, WEDNESDAY, 5'd31, 4'd12, 12'd1980}},
        '{16'd367,   1'b1, '{1'b0, THURSDAY,  5'd1,  4'd1,  12'd1981}},
        '{16'd31,    1'b0, '0},
        '{16'd32,    1'b0, '0},
        '{16'd61,    1'b0, '0},
        '{16'd7306,  1'b0, '0},
        '{16'd7365,  1'b0, '0},
        '{16'd7366,  1'b0, '0},
        '{16'd7671,  1'b0, '0},
        '{16'd7672,  1'b0, '0},
        '{16'd43830, 1'b0, '0},
        '{16'd43831, 1'b0, '0},
        '{16'd43889, 1'b0, '0},
        '{16'd43890, 1'b0, '0},
        '{16'd44195, 1'b0, '0},
        '{16'd44196, 1'b0, '0},
        '{16'h5555,  1'b0, '0},
        '{16'hAAAA,  1'b0, '0},
        '{16'h8000,  1'b0, '0},
        '{16'hFFFE,  1'b0, '0},
        '{16'hFFFF,  1'b0, '0}
    };

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic [dcd_pkg::IN_W-1:0]       s_axis_tdata  = '0;
    logic                           m_axis_tready = 1'b0;
    wire                            s_axis_tready;
    wire                            m_axis_tvalid;
    wire  [dcd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    wire                            m_axis_tuser;

    pending_date_t pending_dates [$];
    int            mismatches  = 0;
    int            idle_cycles = 0;

    day_count_to_calendar_date dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit is_leap_year(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    function automatic calendar_date_t date_of_count(input logic [15:0] count);
        calendar_date_t d;
        int unsigned    left;
        int unsigned    yr;
        int unsigned    mo;
        int unsigned    span;
        d = '0;
        if (count == 0) begin
            d.invalid = 1'b1;
            return d;
        end
        left = count;
        yr   = 1980;
        while (1) begin
            span = is_leap_year(yr) ? 366 : 365;
            if (left <= span) break;
            left -= span;
            yr++;
        end
        mo = 0;
        while (mo < DECEMBER) begin
            span = MONTH_DAYS[mo] + ((mo == FEBRUARY && is_leap_year(yr)) ? 1 : 0);
            if (left <= span) break;
            left -= span;
            mo++;
        end
        span   = (int'(count) + 1) % 7;
        d.year  = yr[11:0];
        d.month = 4'(mo + 1);
        d.mday  = left[4:0];
        d.wday  = span[2:0];
        return d;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            9:             return $urandom_range(20, 250);
            default:       return $urandom_range(1, 4);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_CAP) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_count(input logic [15:0] count, input logic typed,
                              input calendar_date_t typed_date, input int unsigned gap);
        pending_date_t entry;
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = 16'($urandom);
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = count;
        do @(posedge aclk); while (!s_axis_tready);
        entry.count = count;
        entry.date  = typed ? typed_date : date_of_count(count);
        pending_dates.push_back(entry);
        @(negedge aclk);
    endtask

    initial begin
        int unsigned run;
        int unsigned gap;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 1500)
                                              : $urandom_range(1, 20);
            m_axis_tready = 1'b1;
            repeat (run) @(negedge aclk);
            gap = pick_gap();
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        calendar_date_t got;
        pending_date_t  want;
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("** day_count_to_calendar_date: FAILED **");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata};
                if (pending_dates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end else begin
                    want = pending_dates.pop_front();
                    if (got.year !== want.date.year)
                        report_mismatch($sformatf("count %0d year %0d, want %0d",
                                                  want.count, got.year, want.date.year));
                    if (got.month !== want.date.month)
                        report_mismatch($sformatf("count %0d month %0d, want %0d",
                                                  want.count, got.month, want.date.month));
                    if (got.mday !== want.date.mday)
                        report_mismatch($sformatf("count %0d day_of_month %0d, want %0d",
                                                  want.count, got.mday, want.date.mday));
                    if (got.wday !== want.date.wday)
                        report_mismatch($sformatf("count %0d day_of_week %0d, want %0d",
                                                  want.count, got.wday, want.date.wday));
                    if (got.invalid !== want.date.invalid)
                        report_mismatch($sformatf("count %0d invalid %0d, want %0d",
                                                  want.count, got.invalid, want.date.invalid));
                end
            end
        end
    end

    initial begin
        int unsigned   i;
        int unsigned   yr;
        int unsigned   y;
        int unsigned   count32;
        logic [15:0]   count;
        directed_row_t row;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < DIRECTED_ROWS; i++) begin
            row = directed_table[i];
            send_count(row.count, row.typed, row.date, pick_gap());
        end

        for (i = 0; i < RANDOM_COUNTS; i++) begin
            case ($urandom_range(0, 9))
                0: count = 16'($urandom_range(0, 3));
                1, 2: begin
                    // around the start of a year, or the end of February
                    yr      = $urandom_range(1981, 2159);
                    count32 = 1;
                    for (y = 1980; y < yr; y++) begin
                        count32 += is_leap_year(y) ? 366 : 365;
                    end
                    case ($urandom_range(0, 3))
                        0:       count32 -= 1;
                        2:       count32 += 58;
                        3:       count32 += 59;
                        default: ;
                    endcase
                    count = count32[15:0];
                end
                3:       count = 16'($urandom_range(0, 1000));
                4:       count = 16'($urandom_range(60000, 65535));
                default: count = 16'($urandom_range(0, 65535));
            endcase
            send_count(count, 1'b0, '0, (i % 150 < 30) ? 0 : pick_gap());
        end
        s_axis_tvalid = 1'b0;

        while (pending_dates.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_dates.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_dates.size()));
        end

        if (mismatches == 0) begin
            $display("** day_count_to_calendar_date: PASSED **");
        end else begin
            $display("** day_count_to_calendar_date: FAILED **");
        end
        $finish;
    end

endmodule
